// ----- rtl/bpa_pkg.sv -----
// Shared constants, codes and types of the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int FRAME_W  = 20;
  localparam int ORDER_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int TOTAL_W  = 13;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_NUM_PAGES  = 4096;
  localparam int DEF_TOP_ORDER  = 10;
  localparam int DEF_MAX_BLOCKS = 16;

  localparam int RESET_POOL_PAGES = 4096;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OOM = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 1'd1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_XOR
  } alu_op_e;

  // per-field write enables of the page store
  typedef struct packed {
    logic link;
    logic order;
    logic free;
  } mem_we_t;

endpackage

// ----- rtl/bpa_alu.sv -----
// Shared add / subtract / xor unit with a less-than flag.
`timescale 1ns / 1ps
module bpa_alu #(
  parameter int W = 22
) (
  input  bpa_pkg::alu_op_e op_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output logic [W-1:0]     res_o,
  output logic             lt_o
);

  logic [W:0] diff;

  assign diff = {1'b0, a_i} - {1'b0, b_i};
  assign lt_o = diff[W];

  always_comb begin
    case (op_i)
      bpa_pkg::ALU_ADD: res_o = a_i + b_i;
      bpa_pkg::ALU_SUB: res_o = diff[W-1:0];
      bpa_pkg::ALU_XOR: res_o = a_i ^ b_i;
      default:          res_o = '0;
    endcase
  end

endmodule

// ----- rtl/bpa_mem.sv -----
// Per-page store: next link, block order and free flag, one read and one write port.
`timescale 1ns / 1ps
module bpa_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int LW    = 13,
  parameter int OW    = 4
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [LW-1:0]    rd_link_o,
  output logic [OW-1:0]    rd_order_o,
  output logic             rd_free_o,
  input  bpa_pkg::mem_we_t we_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [LW-1:0]    wr_link_i,
  input  logic [OW-1:0]    wr_order_i,
  input  logic             wr_free_i
);

  logic [LW-1:0] link_mem  [DEPTH];
  logic [OW-1:0] order_mem [DEPTH];
  logic          free_mem  [DEPTH];

  logic [LW-1:0] rd_link_q;
  logic [OW-1:0] rd_order_q;
  logic          rd_free_q;

  always_ff @(posedge clk_i) begin
    if (we_i.link) link_mem[wr_addr_i] <= wr_link_i;
    if (we_i.order) order_mem[wr_addr_i] <= wr_order_i;
    if (we_i.free) free_mem[wr_addr_i] <= wr_free_i;
    rd_link_q  <= link_mem[rd_addr_i];
    rd_order_q <= order_mem[rd_addr_i];
    rd_free_q  <= free_mem[rd_addr_i];
  end

  assign rd_link_o  = rd_link_q;
  assign rd_order_o = rd_order_q;
  assign rd_free_o  = rd_free_q;

endmodule

// ----- rtl/buddy_page_allocator.sv -----
// Buddy page allocator: sequencer, list heads, config registers and result register.
`timescale 1ns / 1ps
// A bad request goes straight to the response; an allocate scans the lists, pops and
//   splits each block, skipping empty lists; a free checks each block, merges it with
//   free buddies and walks the buddy's list to unlink it, all through the one page-store
//   port.
// Throughput: one transaction at a time; the next is accepted once the result is queued.
// Reset: clears control state, then sweeps the page store, stalling
//   input; every pool-size write restarts that sweep.
module buddy_page_allocator #(
  parameter int NUM_PAGES  = bpa_pkg::DEF_NUM_PAGES,
  parameter int TOP_ORDER  = bpa_pkg::DEF_TOP_ORDER,
  parameter int MAX_BLOCKS = bpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpa_pkg::FRAME_W-1:0]    cfg_data_i,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [bpa_pkg::ORDER_W-1:0]    block_order_i,
  input  logic [bpa_pkg::COUNT_W-1:0]    block_count_i,
  input  logic [bpa_pkg::FRAME_W-1:0]    frame_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bpa_pkg::STATUS_W-1:0]   status_o,
  output logic [bpa_pkg::FRAME_W-1:0]    first_frame_o
);

  localparam int PW = $clog2(NUM_PAGES);        // page index
  localparam int LW = $clog2(NUM_PAGES + 1);    // page index or end-of-list code
  localparam int DW = ((PW > bpa_pkg::FRAME_W) ? PW : bpa_pkg::FRAME_W) + 2;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int HW = $clog2(TOP_ORDER + 1);
  localparam int SW = LW + 1;
  localparam int OW = bpa_pkg::ORDER_W;
  localparam int FW = bpa_pkg::FRAME_W;
  localparam int POOL_RST = (NUM_PAGES < bpa_pkg::RESET_POOL_PAGES) ?
                            NUM_PAGES : bpa_pkg::RESET_POOL_PAGES;
  localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_POP,
    S_ALLOC_SPLIT,
    S_ALLOC_DONE,
    S_ROLL_NEXT,
    S_FREE_START,
    S_FREE_NEXT,
    S_FB_CHECK,
    S_FB_FREE,
    S_FB_BUDDY,
    S_FB_BCHK,
    S_UL_STEP,
    S_UL_WAIT,
    S_FB_MERGE,
    S_FB_PUSH,
    S_RESP
  } state_e;

  state_e state_q;

  // config
  logic [FW-1:0] base_q;
  logic [LW-1:0] pool_q;
  logic [LW-1:0] pool_new;

  // list heads, one per order
  logic [LW-1:0] head_q [TOP_ORDER+1];
  logic [HW-1:0] lh_idx;
  logic [LW-1:0] lh_rd;

  // request
  logic          type_q;
  logic [OW-1:0] ord_q;
  logic [CW-1:0] cnt_q;
  logic [FW-1:0] frame_q;

  // sequencer working registers
  logic [CW-1:0] i_q;
  logic [CW-1:0] k_q;
  logic [OW-1:0] j_q;
  logic [OW-1:0] jn;
  logic [OW-1:0] o_q;
  logic [LW-1:0] p_q;
  logic [DW-1:0] pf_q;
  logic [DW-1:0] idx_q;
  logic [PW-1:0] b_q;
  logic [LW-1:0] cur_q;
  logic [LW-1:0] prev_q;
  logic [SW-1:0] steps_q;
  logic [PW-1:0] clr_q;
  logic [PW-1:0] gr_q [MAX_BLOCKS];

  logic [DW-1:0] ord_size;
  logic [DW-1:0] hi_idx;
  logic [DW-1:0] lo_idx;

  // result
  logic [bpa_pkg::STATUS_W-1:0] res_status_q;
  logic [FW-1:0]                res_first_q;
  logic                         out_valid_q;
  logic [bpa_pkg::STATUS_W-1:0] status_q;
  logic [FW-1:0]                first_q;

  // shared unit
  bpa_pkg::alu_op_e alu_op;
  logic [DW-1:0]    alu_a;
  logic [DW-1:0]    alu_b;
  logic [DW-1:0]    alu_res;
  logic             alu_lt;

  // page store port
  logic [PW-1:0]    rd_addr;
  logic [LW-1:0]    rd_link;
  logic [OW-1:0]    rd_order;
  logic             rd_free;
  bpa_pkg::mem_we_t mem_we;
  logic [PW-1:0]    wr_addr;
  logic [LW-1:0]    wr_link;
  logic [OW-1:0]    wr_order;
  logic             wr_free;

  logic fb_fail;

  bpa_alu #(.W(DW)) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .lt_o  (alu_lt)
  );

  bpa_mem #(.DEPTH(NUM_PAGES), .AW(PW), .LW(LW), .OW(OW)) u_mem (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .rd_link_o  (rd_link),
    .rd_order_o (rd_order),
    .rd_free_o  (rd_free),
    .we_i       (mem_we),
    .wr_addr_i  (wr_addr),
    .wr_link_i  (wr_link),
    .wr_order_i (wr_order),
    .wr_free_i  (wr_free)
  );

  // pool size after a pool-size write; values past the store act as the store size
  assign pool_new = (32'(cfg_data_i[bpa_pkg::TOTAL_W-1:0]) > NUM_PAGES) ?
                    NIL : LW'(cfg_data_i[bpa_pkg::TOTAL_W-1:0]);

  assign jn       = j_q - OW'(1);
  assign ord_size = DW'(1) << ord_q;
  assign hi_idx   = (DW'(b_q) > idx_q) ? DW'(b_q) : idx_q;
  assign lo_idx   = (DW'(b_q) < idx_q) ? DW'(b_q) : idx_q;
  assign lh_rd    = head_q[lh_idx];

  // block check at entry of a block free: in pool, aligned, fits
  assign fb_fail = (idx_q >= DW'(pool_q)) || ((idx_q & (ord_size - DW'(1))) != '0) ||
                   (alu_res > DW'(pool_q));

  // datapath steering per state
  always_comb begin
    alu_op   = bpa_pkg::ALU_ADD;
    alu_a    = idx_q;
    alu_b    = ord_size;
    lh_idx   = j_q[HW-1:0];
    rd_addr  = idx_q[PW-1:0];
    mem_we   = '0;
    wr_addr  = idx_q[PW-1:0];
    wr_link  = NIL;
    wr_order = ord_q;
    wr_free  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we   = '{link: 1'b1, order: 1'b1, free: 1'b1};
        wr_addr  = clr_q;
        wr_link  = ((LW'(clr_q) < pool_q) && (clr_q != '0)) ? LW'(clr_q - PW'(1)) : NIL;
        wr_order = '0;
        wr_free  = (LW'(clr_q) < pool_q);
      end
      S_ALLOC_SCAN: begin
        rd_addr = lh_rd[PW-1:0];
      end
      S_ALLOC_SPLIT: begin
        alu_a = DW'(p_q);
        alu_b = DW'(1) << jn;
        if (j_q > ord_q) begin
          // upper half goes onto the list one order down
          lh_idx = jn[HW-1:0];
          if (alu_res < DW'(NUM_PAGES)) begin
            mem_we   = '{link: 1'b1, order: 1'b1, free: 1'b1};
            wr_addr  = alu_res[PW-1:0];
            wr_link  = lh_rd;
            wr_order = jn;
            wr_free  = 1'b1;
          end
        end else begin
          mem_we   = '{link: 1'b1, order: 1'b1, free: 1'b1};
          wr_addr  = p_q[PW-1:0];
          wr_link  = NIL;
          wr_order = ord_q;
          wr_free  = 1'b0;
        end
      end
      S_ALLOC_DONE: begin
        alu_a = DW'(base_q);
        alu_b = DW'(gr_q[0]);
      end
      S_FREE_START: begin
        alu_op = bpa_pkg::ALU_SUB;
        alu_a  = DW'(frame_q);
        alu_b  = DW'(base_q);
      end
      S_FREE_NEXT: begin
        alu_a = pf_q;
      end
      S_FB_BUDDY: begin
        alu_op  = bpa_pkg::ALU_XOR;
        alu_b   = DW'(1) << o_q;
        rd_addr = alu_res[PW-1:0];
      end
      S_FB_BCHK: begin
        lh_idx = o_q[HW-1:0];
      end
      S_UL_STEP: begin
        rd_addr = cur_q[PW-1:0];
      end
      S_UL_WAIT: begin
        lh_idx = o_q[HW-1:0];
        if ((cur_q == LW'(b_q)) && (prev_q != NIL)) begin
          mem_we.link = 1'b1;
          wr_addr     = prev_q[PW-1:0];
          wr_link     = rd_link;
        end
      end
      S_FB_MERGE: begin
        mem_we.free = 1'b1;
        wr_addr     = hi_idx[PW-1:0];
        wr_free     = 1'b0;
      end
      S_FB_PUSH: begin
        lh_idx   = o_q[HW-1:0];
        mem_we   = '{link: 1'b1, order: 1'b1, free: 1'b1};
        wr_link  = lh_rd;
        wr_order = o_q;
        wr_free  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer, list heads and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      base_q      <= '0;
      pool_q      <= LW'(POOL_RST);
      out_valid_q <= 1'b0;
      for (int h = 0; h <= TOP_ORDER; h++) begin
        head_q[h] <= (h == 0) ? LW'(POOL_RST - 1) : NIL;
      end
    end else begin
      // a result taken while a new one loads stays valid; S_RESP handles that case
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) out_valid_q <= 1'b0;

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + PW'(1);
          if (clr_q == PW'(NUM_PAGES - 1)) state_q <= S_IDLE;
        end

        S_IDLE: begin
          if (in_valid_i) begin
            type_q       <= req_type_i;
            ord_q        <= block_order_i;
            cnt_q        <= CW'(block_count_i);
            frame_q      <= frame_i;
            res_first_q  <= '0;
            res_status_q <= bpa_pkg::STATUS_OK;
            i_q          <= '0;
            k_q          <= '0;
            j_q          <= block_order_i;
            if ((32'(block_order_i) > TOP_ORDER) || (block_count_i == '0) ||
                (32'(block_count_i) > MAX_BLOCKS)) begin
              res_status_q <= bpa_pkg::STATUS_BAD;
              state_q      <= S_RESP;
            end else if (req_type_i == bpa_pkg::REQ_ALLOC) begin
              state_q <= S_ALLOC_SCAN;
            end else if (frame_i == '0) begin
              res_status_q <= bpa_pkg::STATUS_BAD;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_FREE_START;
            end
          end
        end

        // smallest non-empty list at or above the order
        S_ALLOC_SCAN: begin
          if (lh_rd < NIL) begin
            p_q     <= lh_rd;
            state_q <= S_ALLOC_POP;
          end else if (32'(j_q) >= TOP_ORDER) begin
            res_status_q <= bpa_pkg::STATUS_OOM;
            k_q          <= '0;
            state_q      <= S_ROLL_NEXT;
          end else begin
            j_q <= j_q + OW'(1);
          end
        end

        S_ALLOC_POP: begin
          head_q[j_q[HW-1:0]] <= rd_link;
          state_q             <= S_ALLOC_SPLIT;
        end

        S_ALLOC_SPLIT: begin
          if (j_q > ord_q) begin
            if (alu_res < DW'(NUM_PAGES)) head_q[jn[HW-1:0]] <= LW'(alu_res);
            j_q <= jn;
          end else begin
            gr_q[i_q[IW-1:0]] <= p_q[PW-1:0];
            i_q               <= i_q + CW'(1);
            j_q               <= ord_q;
            state_q           <= ((i_q + CW'(1)) == cnt_q) ? S_ALLOC_DONE : S_ALLOC_SCAN;
          end
        end

        S_ALLOC_DONE: begin
          res_first_q <= alu_res[FW-1:0];
          state_q     <= S_RESP;
        end

        // out of memory: give back what this transaction took
        S_ROLL_NEXT: begin
          if (k_q == i_q) begin
            state_q <= S_RESP;
          end else begin
            idx_q   <= DW'(gr_q[k_q[IW-1:0]]);
            k_q     <= k_q + CW'(1);
            state_q <= S_FB_CHECK;
          end
        end

        S_FREE_START: begin
          if (alu_lt) begin
            state_q <= S_RESP;
          end else begin
            pf_q    <= alu_res;
            state_q <= S_FREE_NEXT;
          end
        end

        S_FREE_NEXT: begin
          if ((i_q == cnt_q) || (pf_q >= DW'(pool_q))) begin
            state_q <= S_RESP;
          end else begin
            idx_q   <= pf_q;
            pf_q    <= alu_res;
            i_q     <= i_q + CW'(1);
            state_q <= S_FB_CHECK;
          end
        end

        S_FB_CHECK: begin
          if (fb_fail) begin
            state_q <= (type_q == bpa_pkg::REQ_ALLOC) ? S_ROLL_NEXT : S_FREE_NEXT;
          end else begin
            state_q <= S_FB_FREE;
          end
        end

        // double free is skipped
        S_FB_FREE: begin
          if (rd_free) begin
            state_q <= (type_q == bpa_pkg::REQ_ALLOC) ? S_ROLL_NEXT : S_FREE_NEXT;
          end else begin
            o_q     <= ord_q;
            state_q <= S_FB_BUDDY;
          end
        end

        S_FB_BUDDY: begin
          b_q <= alu_res[PW-1:0];
          if ((32'(o_q) >= TOP_ORDER) || (alu_res >= DW'(pool_q))) begin
            state_q <= S_FB_PUSH;
          end else begin
            state_q <= S_FB_BCHK;
          end
        end

        S_FB_BCHK: begin
          if (!rd_free || (rd_order != o_q)) begin
            state_q <= S_FB_PUSH;
          end else begin
            prev_q  <= NIL;
            cur_q   <= lh_rd;
            steps_q <= '0;
            state_q <= S_UL_STEP;
          end
        end

        // walk the buddy's list, bounded so an overlapped pool cannot hang it
        S_UL_STEP: begin
          if ((32'(steps_q) > NUM_PAGES) || (cur_q >= NIL)) begin
            state_q <= S_FB_PUSH;
          end else begin
            state_q <= S_UL_WAIT;
          end
        end

        S_UL_WAIT: begin
          if (cur_q == LW'(b_q)) begin
            if (prev_q == NIL) head_q[o_q[HW-1:0]] <= rd_link;
            state_q <= S_FB_MERGE;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= rd_link;
            steps_q <= steps_q + SW'(1);
            state_q <= S_UL_STEP;
          end
        end

        S_FB_MERGE: begin
          idx_q   <= lo_idx;
          o_q     <= o_q + OW'(1);
          state_q <= S_FB_BUDDY;
        end

        S_FB_PUSH: begin
          head_q[o_q[HW-1:0]] <= LW'(idx_q);
          state_q <= (type_q == bpa_pkg::REQ_ALLOC) ? S_ROLL_NEXT : S_FREE_NEXT;
        end

        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            first_q     <= res_first_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      // config writes; a new pool size rebuilds the lists and restarts the sweep
      if (cfg_we_i) begin
        if (cfg_idx_i == bpa_pkg::CFG_BASE_FRAME) begin
          base_q <= cfg_data_i;
        end else if (cfg_idx_i == bpa_pkg::CFG_POOL_PAGES) begin
          pool_q  <= pool_new;
          clr_q   <= '0;
          state_q <= S_CLEAR;
          for (int h = 0; h <= TOP_ORDER; h++) begin
            head_q[h] <= ((h == 0) && (pool_new != '0)) ? (pool_new - LW'(1)) : NIL;
          end
        end
      end
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign first_frame_o = first_q;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the buddy page allocator.
`timescale 1ns / 1ps
module tb;

  localparam int PAGES       = bpa_pkg::DEF_NUM_PAGES;
  localparam int ORDER_TOP   = bpa_pkg::DEF_TOP_ORDER;
  localparam int BLOCKS_MAX  = bpa_pkg::DEF_MAX_BLOCKS;
  localparam int FW          = bpa_pkg::FRAME_W;
  localparam int OW          = bpa_pkg::ORDER_W;
  localparam int CW          = bpa_pkg::COUNT_W;
  localparam int NIL         = PAGES;  // end-of-list marker
  // Worst case is dominated by long unlink walks and the store sweep after
  // each pool rebuild; this is several times the slowest expected run.
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [bpa_pkg::STATUS_W-1:0] status;
    logic [bpa_pkg::FRAME_W-1:0]  first_frame;
  } alloc_result_t;

  // Mirrors the allocator state and queues the result of every accepted request.
  class alloc_scoreboard;
    logic [FW-1:0]      base;
    int unsigned        total;
    int unsigned        pool;
    int unsigned        head [ORDER_TOP+1];
    int unsigned        link [PAGES];
    logic [OW-1:0]      ord [PAGES];
    bit                 pfree [PAGES];
    int unsigned        granted [BLOCKS_MAX];
    alloc_result_t      expected_q [$];
    int                 errors;
    // blocks held by the bench, available for well-formed frees
    logic [FW-1:0]      held_frame [$];
    int unsigned        held_order [$];

    function new();
      errors = 0;
      base   = '0;
      total  = bpa_pkg::RESET_POOL_PAGES;
      rebuild();
    endfunction

    function void rebuild();
      pool = (total > PAGES) ? PAGES : total;
      for (int i = 0; i <= ORDER_TOP; i++) head[i] = NIL;
      for (int i = 0; i < PAGES; i++) begin
        ord[i] = '0;
        if (i < pool) begin
          link[i]  = (i == 0) ? NIL : i - 1;
          pfree[i] = 1;
        end else begin
          link[i]  = NIL;
          pfree[i] = 0;
        end
      end
      if (pool > 0) head[0] = pool - 1;
      held_frame.delete();
      held_order.delete();
    endfunction

    function void configure(logic [bpa_pkg::CFG_IDX_W-1:0] idx, logic [FW-1:0] val);
      if (idx == bpa_pkg::CFG_BASE_FRAME) begin
        base = val;
      end else begin
        total = 32'(val[bpa_pkg::TOTAL_W-1:0]);
        rebuild();
      end
    endfunction

    function void push_block(int unsigned p, int unsigned o);
      ord[p]   = OW'(o);
      pfree[p] = 1;
      link[p]  = head[o];
      head[o]  = p;
    endfunction

    function bit unlink_block(int unsigned o, int unsigned p);
      int unsigned prev, cur;
      prev = NIL;
      cur  = head[o];
      for (int unsigned steps = 0; steps <= PAGES && cur < NIL; steps++) begin
        if (cur == p) begin
          if (prev == NIL) head[o] = link[cur];
          else link[prev] = link[cur];
          return 1;
        end
        prev = cur;
        cur  = link[cur];
      end
      return 0;
    endfunction

    // Pop the smallest fitting block and split it down, pushing upper halves.
    function int unsigned take_block(int unsigned o);
      int unsigned p, j;
      for (j = o; j <= ORDER_TOP; j++) begin
        p = head[j];
        if (p < NIL) begin
          head[j] = link[p];
          while (j > o) begin
            j--;
            if (p + (1 << j) < NIL) push_block(p + (1 << j), j);
          end
          pfree[p] = 0;
          ord[p]   = OW'(o);
          link[p]  = NIL;
          return p;
        end
      end
      return NIL;
    endfunction

    // Release one block, merging with free buddies up to the top order.
    function void release_block(int unsigned idx, int unsigned o);
      int unsigned sz, b, hi;
      sz = 1 << o;
      if (idx >= pool || (idx & (sz - 1)) != 0 || idx + sz > pool) return;
      if (pfree[idx]) return;
      while (o < ORDER_TOP) begin
        b = idx ^ (1 << o);
        if (b >= pool || !pfree[b] || ord[b] != o) break;
        if (!unlink_block(o, b)) break;
        hi = (b > idx) ? b : idx;
        pfree[hi] = 0;
        idx = (b < idx) ? b : idx;
        o++;
      end
      push_block(idx, o);
    endfunction

    function void note_request(logic rtype, logic [OW-1:0] o,
                               logic [CW-1:0] cnt, logic [FW-1:0] fr);
      alloc_result_t r;
      int unsigned   p;
      r = '0;
      if (o > ORDER_TOP || cnt == 0 || cnt > BLOCKS_MAX) begin
        r.status = bpa_pkg::STATUS_BAD;
      end else if (rtype == bpa_pkg::REQ_ALLOC) begin
        r.status = bpa_pkg::STATUS_OK;
        for (int i = 0; i < cnt; i++) begin
          p = take_block(o);
          if (p == NIL) begin
            // roll back what this request already took
            for (int k = 0; k < i; k++) release_block(granted[k], o);
            r.status = bpa_pkg::STATUS_OOM;
            break;
          end
          granted[i] = p;
        end
        if (r.status == bpa_pkg::STATUS_OK) begin
          r.first_frame = FW'(32'(base) + granted[0]);
          for (int i = 0; i < cnt; i++) begin
            held_frame.push_back(FW'(32'(base) + granted[i]));
            held_order.push_back(32'(o));
          end
        end
      end else if (fr == 0) begin
        r.status = bpa_pkg::STATUS_BAD;
      end else if (fr >= base) begin
        p = 32'(fr) - 32'(base);
        for (int i = 0; i < cnt; i++) begin
          if (p >= pool) break;
          release_block(p, o);
          p += 1 << o;
        end
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [bpa_pkg::STATUS_W-1:0] st, logic [FW-1:0] ff);
      alloc_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d frame=%h", st, ff));
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status)
        report($sformatf("status got %0d want %0d", st, e.status));
      if (ff !== e.first_frame)
        report($sformatf("first_frame got %h want %h", ff, e.first_frame));
    endtask
  endclass

  logic                          clk_i, rst_ni;
  logic                          cfg_we_i;
  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [FW-1:0]                 cfg_data_i;
  logic                          in_valid_i, in_stall_o;
  logic                          req_type_i;
  logic [OW-1:0]                 block_order_i;
  logic [CW-1:0]                 block_count_i;
  logic [FW-1:0]                 frame_i;
  logic                          out_valid_o, out_stall_i;
  logic [bpa_pkg::STATUS_W-1:0]  status_o;
  logic [FW-1:0]                 first_frame_o;

  alloc_scoreboard sb = new();
  int unsigned     cycles = 0;
  int              burst_left = 0;

  buddy_page_allocator dut (.*);

  // 2 ns clock
  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: switches between free-running, random and long-stall
  // stretches so stalls land on every phase of the result path.
  int unsigned stall_mode = 0, stall_len = 0;
  always @(posedge clk_i) begin
    if (stall_len == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_len  = $urandom_range(5, 60);
    end else begin
      stall_len--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 1);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Result monitor: every accepted result transaction is checked in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(status_o, first_frame_o);
  end

  // Sender side: one request transaction; valid stays high into the next one
  // unless the burst logic below opens a gap.
  task automatic send(logic rtype, logic [OW-1:0] o, logic [CW-1:0] cnt,
                      logic [FW-1:0] fr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    req_type_i    <= rtype;
    block_order_i <= o;
    block_count_i <= cnt;
    frame_i       <= fr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(rtype, o, cnt, fr);
  endtask

  // Hold off the sender until every outstanding result has drained.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write, only ever issued with the block idle.
  task automatic write_reg(logic [bpa_pkg::CFG_IDX_W-1:0] idx, logic [FW-1:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.configure(idx, val);
  endtask

  // Random traffic: mostly well-formed allocs and frees of held blocks,
  // the rest raw noise and frees of arbitrary pool pages.
  task automatic random_traffic(int n);
    int unsigned sel, pick, o;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 59) == 0) drain();
      if (sel < 45) begin
        o = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ORDER_TOP) : $urandom_range(0, 3);
        send(bpa_pkg::REQ_ALLOC, OW'(o),
             CW'(($urandom_range(0, 5) == 0) ? $urandom_range(1, BLOCKS_MAX) :
                                               $urandom_range(1, 4)),
             FW'($urandom()));
      end else if (sel < 80 && sb.held_frame.size() != 0) begin
        pick = $urandom_range(0, sb.held_frame.size() - 1);
        send(bpa_pkg::REQ_FREE, OW'(sb.held_order[pick]), CW'($urandom_range(1, 2)),
             sb.held_frame[pick]);
        sb.held_frame.delete(pick);
        sb.held_order.delete(pick);
      end else if (sel < 90) begin
        send(bpa_pkg::REQ_FREE, OW'($urandom_range(0, ORDER_TOP)), CW'($urandom_range(1, 3)),
             FW'(32'(sb.base) + $urandom_range(0, (sb.pool > 0) ? sb.pool : 1)));
      end else begin
        send(1'($urandom_range(0, 1)), OW'($urandom_range(0, 15)),
             CW'($urandom_range(0, 31)), FW'($urandom()));
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= bpa_pkg::CFG_BASE_FRAME;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    req_type_i    <= bpa_pkg::REQ_ALLOC;
    block_order_i <= '0;
    block_count_i <= '0;
    frame_i       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: bad requests, OOM rollback, alloc/free corner cases
    send(bpa_pkg::REQ_ALLOC, 4'd11, 5'd1, 20'd0);
    send(bpa_pkg::REQ_ALLOC, 4'd15, 5'd31, 20'hFFFFF);
    send(bpa_pkg::REQ_ALLOC, 4'd0, 5'd0, 20'd0);
    send(bpa_pkg::REQ_ALLOC, 4'd0, 5'd17, 20'd0);
    send(bpa_pkg::REQ_FREE, 4'd0, 5'd1, 20'd0);
    send(bpa_pkg::REQ_FREE, 4'd11, 5'd1, 20'd5);
    send(bpa_pkg::REQ_FREE, 4'd0, 5'd0, 20'd5);
    send(bpa_pkg::REQ_FREE, 4'd3, 5'd16, 20'hFFFFF);
    send(bpa_pkg::REQ_ALLOC, OW'(ORDER_TOP), 5'd1, 20'd0);   // no top-order block yet
    send(bpa_pkg::REQ_ALLOC, 4'd0, CW'(BLOCKS_MAX), 20'd0);  // pages 4095..4080
    send(bpa_pkg::REQ_ALLOC, 4'd2, 5'd2, 20'd0);            // split from order 0 fails
    send(bpa_pkg::REQ_FREE, 4'd1, 5'd1, 20'd4081);          // misaligned
    send(bpa_pkg::REQ_FREE, 4'd0, 5'd1, 20'd4096);          // past the pool
    send(bpa_pkg::REQ_FREE, 4'd2, 5'd1, 20'd4084);          // head inside allocated run
    send(bpa_pkg::REQ_FREE, 4'd0, CW'(BLOCKS_MAX), 20'd4080);  // merges
    send(bpa_pkg::REQ_FREE, 4'd0, CW'(BLOCKS_MAX), 20'd4080);  // double free
    send(bpa_pkg::REQ_ALLOC, 4'd0, 5'd1, 20'd0);
    send(bpa_pkg::REQ_ALLOC, 4'd4, 5'd1, 20'd0);

    // drain the top half of the pool and give it back so merges reach the cap
    write_reg(bpa_pkg::CFG_POOL_PAGES, FW'(PAGES));
    for (int i = 0; i < 128; i++) send(bpa_pkg::REQ_ALLOC, 4'd0, CW'(BLOCKS_MAX), 20'd0);
    for (int i = 0; i < 128; i++)
      send(bpa_pkg::REQ_FREE, 4'd0, CW'(BLOCKS_MAX), FW'(PAGES - 16 * (i + 1)));
    send(bpa_pkg::REQ_ALLOC, OW'(ORDER_TOP), 5'd4, 20'd0);   // partly satisfied, rolled back
    send(bpa_pkg::REQ_ALLOC, OW'(ORDER_TOP), 5'd1, 20'd0);
    sb.held_frame.delete();
    sb.held_order.delete();
    random_traffic(20);

    write_reg(bpa_pkg::CFG_BASE_FRAME, 20'h12345);
    write_reg(bpa_pkg::CFG_POOL_PAGES, 20'd64);
    random_traffic(70);

    write_reg(bpa_pkg::CFG_BASE_FRAME, 20'hFFFFF);    // base at the frame limit
    write_reg(bpa_pkg::CFG_POOL_PAGES, 20'd1);
    random_traffic(20);

    write_reg(bpa_pkg::CFG_BASE_FRAME, 20'd0);
    write_reg(bpa_pkg::CFG_POOL_PAGES, 20'd0);        // empty pool
    random_traffic(10);

    write_reg(bpa_pkg::CFG_BASE_FRAME, 20'd1000);
    write_reg(bpa_pkg::CFG_POOL_PAGES, 20'd8191);     // clamps to the full pool
    random_traffic(40);

    write_reg(bpa_pkg::CFG_BASE_FRAME, 20'd7);
    write_reg(bpa_pkg::CFG_POOL_PAGES, 20'd100);
    random_traffic(70);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (sb.expected_q.size() != 0)
        sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
